>>> design/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Types, constants and helpers shared by the nearest palette colour search.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_W           = 8;
  localparam int DIST_W            = 20;
  localparam int APB_AW            = 2;
  localparam int APB_DW            = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // redmean weights: 512 + rmean for red, 767 - rmean for blue
  localparam logic [9:0] RED_BIAS  = 10'd512;
  localparam logic [9:0] BLUE_BIAS = 10'd767;

  localparam logic [APB_AW-1:0] ADDR_LAST_ENTRY = 2'd0;
  localparam logic [7:0]        LAST_ENTRY_RST  = 8'd255;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic used;
    rgb_t color;
  } ram_word_t;

  typedef struct packed {
    op_t                operation;
    logic [7:0]         entry_index;
    logic               entry_used;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        best_index;
    logic [DIST_W-1:0] best_distance;
    logic              match_found;
  } out_item_t;

  // tags that travel beside each palette entry through the distance pipe
  typedef struct packed {
    logic vld;
    logic last;
    logic used;
  } pipe_ctl_t;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> design/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module npcs_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/npcs_dist.sv
// ----------------------------------------------------------------------------
// npcs_dist
// Four-stage redmean distance pipe: differences, squares, weighting, sum.
// ----------------------------------------------------------------------------
module npcs_dist #(
  parameter int IDX_W = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            flush,
  input  npcs_pkg::pipe_ctl_t             in_ctl,
  input  logic [IDX_W-1:0]                in_idx,
  input  npcs_pkg::rgb_t                  in_entry,
  input  npcs_pkg::rgb_t                  qry,
  output npcs_pkg::pipe_ctl_t             out_ctl,
  output logic [IDX_W-1:0]                out_idx,
  output logic [npcs_pkg::DIST_W-1:0]     out_dist
);

  localparam int STAGES = 4;

  npcs_pkg::pipe_ctl_t ctl_r [STAGES];
  logic [IDX_W-1:0]    idx_r [STAGES];

  // stage 1
  logic [7:0]  dr_r, dg_r, db_r, rmean_r;
  logic [8:0]  rsum;
  // stage 2
  logic [15:0] dr2_r, dg2_r, db2_r;
  logic [9:0]  wr_r, wb_r;
  // stage 3
  logic [25:0] pr, pb;
  logic [17:0] tr_r, tg_r, tb_r;
  // stage 4
  logic [npcs_pkg::DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (flush) begin
      for (int k = 0; k < STAGES; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k < STAGES; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  assign rsum = {1'b0, qry.red} + {1'b0, in_entry.red};
  assign pr   = wr_r * dr2_r;
  assign pb   = wb_r * db2_r;

  always_ff @(posedge clk) begin
    idx_r[0] <= in_idx;
    for (int k = 1; k < STAGES; k++) begin
      idx_r[k] <= idx_r[k-1];
    end

    dr_r    <= npcs_pkg::abs_diff(qry.red,   in_entry.red);
    dg_r    <= npcs_pkg::abs_diff(qry.green, in_entry.green);
    db_r    <= npcs_pkg::abs_diff(qry.blue,  in_entry.blue);
    rmean_r <= rsum[8:1];

    dr2_r <= dr_r * dr_r;
    dg2_r <= dg_r * dg_r;
    db2_r <= db_r * db_r;
    wr_r  <= npcs_pkg::RED_BIAS + {2'b00, rmean_r};
    wb_r  <= npcs_pkg::BLUE_BIAS - {2'b00, rmean_r};

    tr_r <= pr[25:8];
    tg_r <= {dg2_r, 2'b00};
    tb_r <= pb[25:8];

    // three 18-bit terms never reach 2^20, so no saturation is needed here
    dist_r <= npcs_pkg::DIST_W'(tr_r) + npcs_pkg::DIST_W'(tg_r)
            + npcs_pkg::DIST_W'(tb_r);
  end

  assign out_ctl  = ctl_r[STAGES-1];
  assign out_idx  = idx_r[STAGES-1];
  assign out_dist = dist_r;

endmodule

>>> design/nearest_palette_color_search_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core
// Holds a palette of RGB entries in one RAM with a used bit per entry and
// returns, for each query pixel, the first used entry at the smallest redmean
// distance among indices 0 to last_entry. A write item gives no result. A
// query scans N = min(last_entry, PALETTE_DEPTH-1) + 1 entries at one per
// cycle, bounded by the single RAM read port; its result passes through the
// RAM read, the four distance stages, the hand-over to the output state and
// the result load, and the input is stalled until then. An exact match ends
// the scan early. After reset a clearing pass writes every RAM entry, during
// which no item is taken; register writes are taken at any time. When no
// entry is used the result is index 0, distance 1048575 and match_found 0.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_core #(
  parameter int PALETTE_DEPTH = npcs_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  npcs_pkg::in_item_t          in_data,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output npcs_pkg::out_item_t         out_data,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [npcs_pkg::APB_AW-1:0] paddr,
  input  logic [npcs_pkg::APB_DW-1:0] pwdata,
  output logic [npcs_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);
  localparam logic [CW-1:0] TOP_IDX = CW'(PALETTE_DEPTH - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]                  last_entry_r;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]               rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]               lim_r, lim_nxt;
  logic                        issue_r, issue_nxt;
  npcs_pkg::pipe_ctl_t         rd_ctl_r, rd_ctl_nxt;
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  npcs_pkg::rgb_t              qry_r, qry_nxt;
  logic                        found_r, found_nxt;
  logic [AW-1:0]               best_idx_r, best_idx_nxt;
  logic [npcs_pkg::DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic                        out_valid_r, out_valid_nxt;
  npcs_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                        in_accept;
  logic                        idx_ok;
  logic [CW-1:0]               lim_wide;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  npcs_pkg::ram_word_t         ram_wdata, ram_rdata;

  npcs_pkg::pipe_ctl_t         dist_in_ctl, res_ctl;
  logic [AW-1:0]               res_idx;
  logic [npcs_pkg::DIST_W-1:0] res_dist;
  logic                        res_upd, done, flush;

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;
  assign prdata = (paddr == npcs_pkg::ADDR_LAST_ENTRY)
                ? {{(npcs_pkg::APB_DW-8){1'b0}}, last_entry_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_entry_r <= npcs_pkg::LAST_ENTRY_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr == npcs_pkg::ADDR_LAST_ENTRY) begin
      last_entry_r <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------- palette
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign idx_ok    = CW'(in_data.entry_index) < DEPTH_C;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_accept && in_data.operation == npcs_pkg::OP_WRITE && idx_ok) begin
      ram_we          = 1'b1;
      ram_waddr       = AW'(in_data.entry_index);
      ram_wdata.used  = in_data.entry_used;
      ram_wdata.color = '{red: in_data.red, green: in_data.green, blue: in_data.blue};
    end
  end

  npcs_ram #(
    .WIDTH ($bits(npcs_pkg::ram_word_t)),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- distance
  assign dist_in_ctl = '{vld: rd_ctl_r.vld, last: rd_ctl_r.last, used: ram_rdata.used};

  npcs_dist #(
    .IDX_W (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .in_ctl   (dist_in_ctl),
    .in_idx   (rd_idx_r),
    .in_entry (ram_rdata.color),
    .qry      (qry_r),
    .out_ctl  (res_ctl),
    .out_idx  (res_idx),
    .out_dist (res_dist)
  );

  // first strictly smaller distance wins; a zero distance on a used entry ends the scan
  assign res_upd = res_ctl.vld && res_ctl.used && (!found_r || res_dist < best_dist_r);
  assign done    = res_ctl.vld && (res_ctl.last || (res_ctl.used && res_dist == '0));
  assign flush   = (state_r == ST_SCAN) && done;

  assign lim_wide = (CW'(last_entry_r) > TOP_IDX) ? TOP_IDX : CW'(last_entry_r);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    rd_addr_nxt   = rd_addr_r;
    lim_nxt       = lim_r;
    issue_nxt     = issue_r;
    rd_ctl_nxt    = '0;
    rd_idx_nxt    = rd_addr_r;
    qry_nxt       = qry_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && in_data.operation == npcs_pkg::OP_QUERY) begin
          state_nxt     = ST_SCAN;
          qry_nxt       = '{red: in_data.red, green: in_data.green, blue: in_data.blue};
          rd_addr_nxt   = '0;
          lim_nxt       = lim_wide[AW-1:0];
          issue_nxt     = 1'b1;
          found_nxt     = 1'b0;
          best_idx_nxt  = '0;
          best_dist_nxt = npcs_pkg::DIST_MAX;
        end
      end
      ST_SCAN: begin
        if (issue_r && !flush) begin
          rd_ctl_nxt.vld  = 1'b1;
          rd_ctl_nxt.last = (rd_addr_r == lim_r);
          rd_addr_nxt     = rd_addr_r + 1'b1;
          if (rd_addr_r == lim_r) begin
            issue_nxt = 1'b0;
          end
        end
        if (res_upd) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = res_idx;
          best_dist_nxt = res_dist;
        end
        if (done) begin
          issue_nxt = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.best_index    = 8'(best_idx_r);
          out_data_nxt.best_distance = best_dist_r;
          out_data_nxt.match_found   = found_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      issue_r     <= 1'b0;
      rd_ctl_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      issue_r     <= issue_nxt;
      rd_ctl_r    <= rd_ctl_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    lim_r       <= lim_nxt;
    rd_idx_r    <= rd_idx_nxt;
    qry_r       <= qry_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
